FILE: rtl/core/crlp_pkg.sv
package crlp_pkg;

   localparam int STACK_DEPTH_DEF = 64;

   localparam int ID_W    = 64;
   localparam int TIME_W  = 27;
   localparam int DEPTH_W = 6;
   localparam int COUNT_W = 32;
   localparam int MAXD_W  = 7;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 27;

   localparam int REQ_TDATA_W = 224;
   localparam int RSP_TDATA_W = 264;

   localparam logic [TIME_W-1:0] MAX_US  = 27'd99999999;
   localparam logic [TIME_W:0]   WRAP_US = 28'd100000000;

   localparam logic [TIME_W-1:0] MIN_COST_RST  = 27'd1000;
   localparam logic [MAXD_W-1:0] MAX_DEPTH_RST = 7'd3;

   typedef enum logic {
      OP_CALL   = 1'b0,
      OP_RETURN = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TIMING_EN  = 2'd0,
      REG_MAIN_THR   = 2'd1,
      REG_MIN_COST   = 2'd2,
      REG_MAX_DEPTH  = 2'd3
   } reg_index_type;

   typedef enum logic {
      PH_CLEAR = 1'b0,
      PH_RUN   = 1'b1
   } phase_type;

   // one word in flight between the stack access and the result register
   typedef struct packed {
      status_type          status;
      logic                pop_ok;
      logic                timing;
      logic                depth_ok;
      logic [DEPTH_W-1:0]  depth;
      logic [TIME_W-1:0]   now;
   } pend_type;

endpackage

FILE: rtl/core/crlp_stack_mem.sv
module crlp_stack_mem
   import crlp_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int AW          = $clog2(STACK_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   output logic               busy,
   input  logic               wr_en,
   input  logic               stamp_wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ID_W-1:0]    wr_class,
   input  logic [ID_W-1:0]    wr_selector,
   input  logic [ID_W-1:0]    wr_link,
   input  logic [TIME_W-1:0]  wr_stamp,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [ID_W-1:0]    rd_class,
   output logic [ID_W-1:0]    rd_selector,
   output logic [ID_W-1:0]    rd_link,
   output logic [TIME_W-1:0]  rd_stamp
);

   logic [3*ID_W-1:0] entry_mem [STACK_DEPTH];
   logic [TIME_W-1:0] stamp_mem [STACK_DEPTH];

   phase_type         phase_ff, phase_in;
   logic [AW-1:0]     clr_idx_ff, clr_idx_in;
   logic [3*ID_W-1:0] rd_entry_ff;
   logic [TIME_W-1:0] rd_stamp_ff;

   logic              st_we;
   logic [AW-1:0]     st_addr;
   logic [TIME_W-1:0] st_data;

   // stamp store resets to zero: sweep it once after reset
   always_comb begin
      phase_in   = phase_ff;
      clr_idx_in = clr_idx_ff;
      busy       = 1'b0;
      st_we      = stamp_wr_en;
      st_addr    = wr_addr;
      st_data    = wr_stamp;
      case (phase_ff)
         PH_CLEAR: begin
            busy       = 1'b1;
            st_we      = 1'b1;
            st_addr    = clr_idx_ff;
            st_data    = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == AW'(STACK_DEPTH - 1)) begin
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
         end
         default: begin
            phase_in = PH_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= {wr_link, wr_selector, wr_class};
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stamp_mem[st_addr] <= st_data;
      end
      if (rd_en) begin
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_class    = rd_entry_ff[ID_W-1:0];
   assign rd_selector = rd_entry_ff[2*ID_W-1:ID_W];
   assign rd_link     = rd_entry_ff[3*ID_W-1:2*ID_W];
   assign rd_stamp    = rd_stamp_ff;

   clear_blocks_push: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("stack write during stamp sweep");

   clear_ends: assert property (@(posedge clock) disable iff (reset)
      (busy && clr_idx_ff == AW'(STACK_DEPTH - 1)) |=> !busy)
      else $error("stamp sweep did not finish");

endmodule

FILE: rtl/core/crlp_log_unit.sv
module crlp_log_unit
   import crlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pend_valid,
   input  pend_type               pend,
   input  logic [ID_W-1:0]        rd_class,
   input  logic [ID_W-1:0]        rd_selector,
   input  logic [ID_W-1:0]        rd_link,
   input  logic [TIME_W-1:0]      rd_stamp,
   input  logic [TIME_W-1:0]      min_cost,
   output logic                   take,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                   fire;
   logic [TIME_W:0]        t_ext;
   logic [TIME_W:0]        cost_ext;
   logic [TIME_W-1:0]      cost;
   logic                   do_log;

   logic                   out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0]     log_total_ff, log_total_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   assign take = !out_valid_ff || rsp_tready;
   assign fire = pend_valid && take;

   // elapsed time, one wrap of the 100 s clock at most
   always_comb begin
      t_ext    = {1'b0, pend.now} + ((pend.now < rd_stamp) ? WRAP_US : '0);
      cost_ext = t_ext - {1'b0, rd_stamp};
      cost     = cost_ext[TIME_W-1:0];
      do_log   = pend.pop_ok && pend.timing && pend.depth_ok && (cost > min_cost);
   end

   always_comb begin
      log_total_in = log_total_ff;
      if (fire && do_log && log_total_ff != '1) begin
         log_total_in = log_total_ff + 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      // status, restore, log_valid, class, selector, depth, cost, count
      out_data_in = {4'b0,
                     log_total_in,
                     do_log ? cost : '0,
                     do_log ? pend.depth : '0,
                     do_log ? rd_selector : '0,
                     do_log ? rd_class : '0,
                     do_log,
                     pend.pop_ok ? rd_link : '0,
                     pend.status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         log_total_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         log_total_ff <= log_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   count_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> log_total_ff >= $past(log_total_ff))
      else $error("record count went backward");

   error_no_log: assert property (@(posedge clock) disable iff (reset)
      (fire && pend.status != ST_OK) |-> !do_log)
      else $error("log record on a failed stack operation");

   count_step: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(log_total_ff))
      else $error("record count moved without a result");

endmodule

FILE: rtl/core/call_return_latency_profiler.sv
// call/return trace unit with latency logging
//
// req channel: one word per call or return event. req_tuser carries the opcode
// (call pushes, return pops); req_tdata carries class, selector, return address
// and the current time in microseconds modulo 100 s.
// rsp channel: exactly one word per accepted event: status, restored address,
// an optional log record (class, selector, depth, cost) and the record count.
// csr port: write-only, one register per cycle when csr_we is high.
//
// the stack lives in two single-port-write memories (identifiers and stamps).
// a push writes the memories in the cycle it is accepted; a pop reads the top
// entry into registered read data, which the evaluation stage then uses. a
// result passes from the evaluation stage into the result register and then
// appears on rsp; a new event can be taken every cycle while the result
// register hands its word on, limited only by that one-stage handoff.
// after reset the stamp memory is cleared, one entry per cycle, until all
// STACK_DEPTH entries are zero; req_tready stays low during that sweep. the
// stack is empty and the record count is zero after reset.
// when rsp_tready is low, the result register holds its word, one more event
// is taken into the evaluation stage, and then req_tready drops.
module call_return_latency_profiler
   import crlp_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: class_id, selector_id, return_addr, now_us, zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: opcode
   input  logic [0:0]             req_tuser,
   // rsp_tdata: status, restore_addr, log_valid, log_class, log_selector,
   // log_depth, log_cost_us, record_count, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int CMPW = AW + MAXD_W + 1;

   // config registers
   logic               timing_en_ff, timing_en_in;
   logic               main_thr_ff, main_thr_in;
   logic [TIME_W-1:0]  min_cost_ff, min_cost_in;
   logic [MAXD_W-1:0]  max_depth_ff, max_depth_in;

   // stack pointer and evaluation stage
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               s1_valid_ff, s1_valid_in;
   pend_type           pend_ff, pend_in;

   logic               busy;
   logic               take;
   logic               acc;
   logic               is_call;
   logic               full;
   logic               empty;
   logic               timing;
   logic               push_ok;
   logic               pop_ok;
   logic [TIME_W-1:0]  now_raw;
   logic [TIME_W-1:0]  now_clamped;
   logic [AW-1:0]      push_idx;
   logic [AW-1:0]      top_idx;

   logic [ID_W-1:0]    rd_class;
   logic [ID_W-1:0]    rd_selector;
   logic [ID_W-1:0]    rd_link;
   logic [TIME_W-1:0]  rd_stamp;

   // config writes
   always_comb begin
      timing_en_in = timing_en_ff;
      main_thr_in  = main_thr_ff;
      min_cost_in  = min_cost_ff;
      max_depth_in = max_depth_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_TIMING_EN: timing_en_in = csr_wdata[0];
            REG_MAIN_THR:  main_thr_in  = csr_wdata[0];
            REG_MIN_COST:  min_cost_in  = csr_wdata[TIME_W-1:0];
            REG_MAX_DEPTH: max_depth_in = csr_wdata[MAXD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_en_ff <= 1'b1;
         main_thr_ff  <= 1'b1;
         min_cost_ff  <= MIN_COST_RST;
         max_depth_ff <= MAX_DEPTH_RST;
      end else begin
         timing_en_ff <= timing_en_in;
         main_thr_ff  <= main_thr_in;
         min_cost_ff  <= min_cost_in;
         max_depth_ff <= max_depth_in;
      end
   end

   // event decode against the current stack pointer
   assign req_tready  = !busy && (!s1_valid_ff || take);
   assign acc         = req_tvalid && req_tready;
   assign is_call     = (req_tuser[0] == OP_CALL);
   assign full        = (cnt_ff == CW'(STACK_DEPTH));
   assign empty       = (cnt_ff == '0);
   assign timing      = timing_en_ff && main_thr_ff;
   assign push_ok     = acc && is_call && !full;
   assign pop_ok      = acc && !is_call && !empty;
   assign now_raw     = req_tdata[3*ID_W +: TIME_W];
   assign now_clamped = (now_raw > MAX_US) ? MAX_US : now_raw;
   assign push_idx    = cnt_ff[AW-1:0];
   assign top_idx     = AW'(cnt_ff - 1'b1);

   always_comb begin
      cnt_in = cnt_ff;
      if (push_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end

      s1_valid_in = s1_valid_ff;
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end

      pend_in.status   = is_call ? (full ? ST_FULL : ST_OK) : (empty ? ST_EMPTY : ST_OK);
      pend_in.pop_ok   = !is_call && !empty;
      pend_in.timing   = timing;
      // depth after the pop is at most max_depth, i.e. top < max_depth + 1
      pend_in.depth_ok = CMPW'(top_idx) < (CMPW'(max_depth_ff) + CMPW'(1));
      pend_in.depth    = DEPTH_W'(top_idx);
      pend_in.now      = now_clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         pend_ff <= pend_in;
      end
   end

   crlp_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .busy        (busy),
      .wr_en       (push_ok),
      .stamp_wr_en (push_ok && timing),
      .wr_addr     (push_idx),
      .wr_class    (req_tdata[0 +: ID_W]),
      .wr_selector (req_tdata[ID_W +: ID_W]),
      .wr_link     (req_tdata[2*ID_W +: ID_W]),
      .wr_stamp    (now_clamped),
      .rd_en       (pop_ok),
      .rd_addr     (top_idx),
      .rd_class    (rd_class),
      .rd_selector (rd_selector),
      .rd_link     (rd_link),
      .rd_stamp    (rd_stamp)
   );

   crlp_log_unit u_log (
      .clock       (clock),
      .reset       (reset),
      .pend_valid  (s1_valid_ff),
      .pend        (pend_ff),
      .rd_class    (rd_class),
      .rd_selector (rd_selector),
      .rd_link     (rd_link),
      .rd_stamp    (rd_stamp),
      .min_cost    (min_cost_ff),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack pointer beyond stack size");

   push_grows: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("push did not advance stack pointer");

   failed_op_holds: assert property (@(posedge clock) disable iff (reset)
      (acc && !push_ok && !pop_ok) |=> $stable(cnt_ff))
      else $error("dropped event moved stack pointer");

endmodule
